// ----- sv/cwsp_pkg.sv -----
// ----------------------------------------------------------------------------
// cwsp_pkg
// Shared types, codes and constants of the command-line word splitter.
// ----------------------------------------------------------------------------
package cwsp_pkg;

   // Default longest line; byte positions saturate one below it.
   localparam int MAX_LINE_DEFAULT = 1024;

   // Result queue depth; it must hold two results beyond what is in flight.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // Result kinds.
   localparam logic [1:0] KIND_BYTE     = 2'd0;
   localparam logic [1:0] KIND_WORD_END = 2'd1;
   localparam logic [1:0] KIND_LINE_OK  = 2'd2;
   localparam logic [1:0] KIND_LINE_ERR = 2'd3;

   // Error codes.
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_EMPTY_LINE = 2'd1;
   localparam logic [1:0] ERR_OPEN_DQ    = 2'd2;
   localparam logic [1:0] ERR_OPEN_SQ    = 2'd3;

   // Lexer modes.
   localparam logic [1:0] MODE_GAP  = 2'd0;
   localparam logic [1:0] MODE_WORD = 2'd1;
   localparam logic [1:0] MODE_DQ   = 2'd2;
   localparam logic [1:0] MODE_SQ   = 2'd3;

   // Characters of interest.
   localparam logic [7:0] CHAR_EOL       = 8'h00;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

   localparam logic [9:0]  WORDS_MAX      = 10'd1023;
   localparam logic [10:0] QUOTE_COL_MAX  = 11'd2047;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [9:0]  word_count;
      logic [1:0]  err_code;
      logic [10:0] error_column;
      logic        last;
   } result_type;

   // Lexer state as seen from outside, for checking.
   typedef struct packed {
      logic [1:0] mode;
      logic       escape_pending;
      logic       words_zero;
      logic       position_zero;
   } lex_status_type;

   function automatic result_type make_result(input logic [1:0]  kind,
                                              input logic [7:0]  data_byte,
                                              input logic [9:0]  word_count,
                                              input logic [1:0]  err_code,
                                              input logic [10:0] error_column);
      result_type r;
      r.kind         = kind;
      r.data_byte    = data_byte;
      r.word_count   = word_count;
      r.err_code     = err_code;
      r.error_column = error_column;
      r.last         = 1'b0;
      return r;
   endfunction

   function automatic logic is_separator(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_NEWLINE);
   endfunction

endpackage

// ----- sv/cwsp_lexer.sv -----
// ----------------------------------------------------------------------------
// cwsp_lexer
// Line state and the decode of one byte into at most two results.
// ----------------------------------------------------------------------------
module cwsp_lexer #(
   parameter int MAX_LINE = cwsp_pkg::MAX_LINE_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  logic [7:0]               char_in,
   output logic [1:0]               res_num,
   output cwsp_pkg::result_type     res0,
   output cwsp_pkg::result_type     res1,
   output cwsp_pkg::lex_status_type status
);

   localparam int POS_W = $clog2(MAX_LINE);
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE - 1);

   logic [1:0]       mode_ff,   mode_in;
   logic             esc_ff,    esc_in;
   logic [POS_W-1:0] pos_ff,    pos_in;
   logic [10:0]      qcol_ff,   qcol_in;
   logic [9:0]       words_ff,  words_in;

   logic [31:0]      col_wide;
   logic [10:0]      col_sat;
   logic             special;
   cwsp_pkg::result_type r0, r1;

   assign col_wide = 32'(pos_ff) + 32'd1;
   assign col_sat  = (col_wide > 32'(cwsp_pkg::QUOTE_COL_MAX)) ?
                     cwsp_pkg::QUOTE_COL_MAX : col_wide[10:0];

   // Bytes that an outside-quote backslash yields alone.
   assign special = (char_in == cwsp_pkg::CHAR_DQUOTE) ||
                    (char_in == cwsp_pkg::CHAR_SQUOTE) ||
                    cwsp_pkg::is_separator(char_in);

   always_comb begin
      mode_in  = mode_ff;
      esc_in   = esc_ff;
      pos_in   = pos_ff;
      qcol_in  = qcol_ff;
      words_in = words_ff;
      res_num  = 2'd0;
      r0       = cwsp_pkg::make_result(cwsp_pkg::KIND_BYTE, 8'd0, 10'd0,
                                       cwsp_pkg::ERR_NONE, 11'd0);
      r1       = r0;

      if (char_in == cwsp_pkg::CHAR_EOL) begin
         res_num = 2'd1;
         if (mode_ff == cwsp_pkg::MODE_DQ) begin
            r0 = cwsp_pkg::make_result(cwsp_pkg::KIND_LINE_ERR, 8'd0, 10'd0,
                                       cwsp_pkg::ERR_OPEN_DQ, qcol_ff);
         end else if (mode_ff == cwsp_pkg::MODE_SQ) begin
            r0 = cwsp_pkg::make_result(cwsp_pkg::KIND_LINE_ERR, 8'd0, 10'd0,
                                       cwsp_pkg::ERR_OPEN_SQ, qcol_ff);
         end else if (pos_ff == '0 && mode_ff == cwsp_pkg::MODE_GAP) begin
            r0 = cwsp_pkg::make_result(cwsp_pkg::KIND_LINE_ERR, 8'd0, 10'd0,
                                       cwsp_pkg::ERR_EMPTY_LINE, 11'd0);
         end else if (mode_ff == cwsp_pkg::MODE_WORD) begin
            res_num = 2'd2;
            r0 = cwsp_pkg::make_result(cwsp_pkg::KIND_WORD_END, 8'd0, 10'd0,
                                       cwsp_pkg::ERR_NONE, 11'd0);
            r1 = cwsp_pkg::make_result(cwsp_pkg::KIND_LINE_OK, 8'd0, words_ff,
                                       cwsp_pkg::ERR_NONE, 11'd0);
         end else begin
            r0 = cwsp_pkg::make_result(cwsp_pkg::KIND_LINE_OK, 8'd0, words_ff,
                                       cwsp_pkg::ERR_NONE, 11'd0);
         end
         mode_in  = cwsp_pkg::MODE_GAP;
         esc_in   = 1'b0;
         pos_in   = '0;
         qcol_in  = 11'd0;
         words_in = 10'd0;
      end else begin
         if (mode_ff == cwsp_pkg::MODE_DQ) begin
            if (esc_ff) begin
               esc_in = 1'b0;
               if (char_in != cwsp_pkg::CHAR_DQUOTE) begin
                  res_num = 2'd2;
                  r0 = cwsp_pkg::make_result(cwsp_pkg::KIND_BYTE,
                                             cwsp_pkg::CHAR_BACKSLASH, 10'd0,
                                             cwsp_pkg::ERR_NONE, 11'd0);
                  r1 = cwsp_pkg::make_result(cwsp_pkg::KIND_BYTE, char_in, 10'd0,
                                             cwsp_pkg::ERR_NONE, 11'd0);
               end else begin
                  res_num = 2'd1;
                  r0 = cwsp_pkg::make_result(cwsp_pkg::KIND_BYTE, char_in, 10'd0,
                                             cwsp_pkg::ERR_NONE, 11'd0);
               end
            end else if (char_in == cwsp_pkg::CHAR_BACKSLASH) begin
               esc_in = 1'b1;
            end else if (char_in == cwsp_pkg::CHAR_DQUOTE) begin
               mode_in = cwsp_pkg::MODE_WORD;
            end else begin
               res_num = 2'd1;
               r0 = cwsp_pkg::make_result(cwsp_pkg::KIND_BYTE, char_in, 10'd0,
                                          cwsp_pkg::ERR_NONE, 11'd0);
            end
         end else if (mode_ff == cwsp_pkg::MODE_SQ) begin
            if (char_in == cwsp_pkg::CHAR_SQUOTE) begin
               mode_in = cwsp_pkg::MODE_WORD;
            end else begin
               res_num = 2'd1;
               r0 = cwsp_pkg::make_result(cwsp_pkg::KIND_BYTE, char_in, 10'd0,
                                          cwsp_pkg::ERR_NONE, 11'd0);
            end
         end else if (esc_ff) begin
            esc_in = 1'b0;
            if (!special) begin
               res_num = 2'd2;
               r0 = cwsp_pkg::make_result(cwsp_pkg::KIND_BYTE,
                                          cwsp_pkg::CHAR_BACKSLASH, 10'd0,
                                          cwsp_pkg::ERR_NONE, 11'd0);
               r1 = cwsp_pkg::make_result(cwsp_pkg::KIND_BYTE, char_in, 10'd0,
                                          cwsp_pkg::ERR_NONE, 11'd0);
            end else begin
               res_num = 2'd1;
               r0 = cwsp_pkg::make_result(cwsp_pkg::KIND_BYTE, char_in, 10'd0,
                                          cwsp_pkg::ERR_NONE, 11'd0);
            end
         end else if (cwsp_pkg::is_separator(char_in)) begin
            if (mode_ff == cwsp_pkg::MODE_WORD) begin
               res_num = 2'd1;
               r0 = cwsp_pkg::make_result(cwsp_pkg::KIND_WORD_END, 8'd0, 10'd0,
                                          cwsp_pkg::ERR_NONE, 11'd0);
               mode_in = cwsp_pkg::MODE_GAP;
            end
         end else begin
            if (mode_ff == cwsp_pkg::MODE_GAP) begin
               if (words_ff != cwsp_pkg::WORDS_MAX) begin
                  words_in = words_ff + 10'd1;
               end
               mode_in = cwsp_pkg::MODE_WORD;
            end
            if (char_in == cwsp_pkg::CHAR_BACKSLASH) begin
               esc_in = 1'b1;
            end else if (char_in == cwsp_pkg::CHAR_DQUOTE) begin
               qcol_in = col_sat;
               mode_in = cwsp_pkg::MODE_DQ;
            end else if (char_in == cwsp_pkg::CHAR_SQUOTE) begin
               qcol_in = col_sat;
               mode_in = cwsp_pkg::MODE_SQ;
            end else begin
               res_num = 2'd1;
               r0 = cwsp_pkg::make_result(cwsp_pkg::KIND_BYTE, char_in, 10'd0,
                                          cwsp_pkg::ERR_NONE, 11'd0);
            end
         end
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 1'b1;
         end
      end

      r0.last = (res_num == 2'd1);
      r1.last = (res_num == 2'd2);
   end

   assign res0 = r0;
   assign res1 = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= cwsp_pkg::MODE_GAP;
         esc_ff   <= 1'b0;
         pos_ff   <= '0;
         qcol_ff  <= 11'd0;
         words_ff <= 10'd0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         esc_ff   <= esc_in;
         pos_ff   <= pos_in;
         qcol_ff  <= qcol_in;
         words_ff <= words_in;
      end
   end

   assign status.mode           = mode_ff;
   assign status.escape_pending = esc_ff;
   assign status.words_zero     = (words_ff == 10'd0);
   assign status.position_zero  = (pos_ff == '0);

endmodule

// ----- sv/cwsp_result_queue.sv -----
// ----------------------------------------------------------------------------
// cwsp_result_queue
// Small result queue taking up to two results a cycle and giving one.
// ----------------------------------------------------------------------------
module cwsp_result_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           push_num,
   input  cwsp_pkg::result_type push0,
   input  cwsp_pkg::result_type push1,
   input  logic                 pop,
   output logic                 room,
   output logic                 head_valid,
   output cwsp_pkg::result_type head
);

   localparam int PW = cwsp_pkg::QUEUE_PTR_W;

   cwsp_pkg::result_type entry_ff [cwsp_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff,  count_in;

   // Room for a full pair of results, independent of the pop this cycle.
   assign room       = count_ff <= (PW+1)'(cwsp_pkg::QUEUE_DEPTH - 2);
   assign head_valid = count_ff != '0;
   assign head       = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + PW'(push_num);
   assign rd_ptr_in = rd_ptr_ff + PW'(pop);
   assign count_in  = count_ff + (PW+1)'(push_num) - (PW+1)'(pop);

   always_ff @(posedge clock) begin
      if (push_num != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push0;
      end
      if (push_num == 2'd2) begin
         entry_ff[wr_ptr_ff + PW'(1)] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- sv/command_line_word_splitter_core.sv -----
// ----------------------------------------------------------------------------
// command_line_word_splitter_core
// Shell-style splitter of a command line into words, one byte per beat.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  req_char_in
//   rsp_      out        rsp_valid/rsp_stall  rsp_kind, rsp_data_byte,
//                                             rsp_word_count, rsp_err_code,
//                                             rsp_error_column, rsp_last
//
// A byte beat is taken every cycle while results drain at the same pace.
// Each byte passes through an input register, is decoded against the line
// state and its zero, one or two results are written into a four-entry
// result queue, from whose head the first result is then offered; a full
// queue holds the byte in the input register. A byte yielding two results
// offers them one after the other, so the sustained rate is one result
// beat per cycle on the rsp_ side while rsp_stall is low. Reset is
// synchronous and returns the line state to between words.
// A stall on the rsp_ side backs up through the queue to req_stall once
// fewer than two queue entries are free.

module command_line_word_splitter_core #(
   parameter int MAX_LINE = cwsp_pkg::MAX_LINE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [9:0]  rsp_word_count,
   output logic [1:0]  rsp_err_code,
   output logic [10:0] rsp_error_column,
   output logic        rsp_last
);

   // Input register: holds the byte until the queue can take its results.
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  char_ff;
   logic        req_take;
   logic        fire;
   logic        room;
   logic        pop;

   logic [1:0]               res_num;
   cwsp_pkg::result_type     res0, res1;
   cwsp_pkg::result_type     head;
   cwsp_pkg::lex_status_type status;

   // The byte in the input register is decoded once the queue has room
   // for the largest possible pair of results.
   assign fire      = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in = req_take || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         char_ff <= req_char_in;
      end
   end

   cwsp_lexer #(
      .MAX_LINE (MAX_LINE)
   ) u_lexer (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .char_in (char_ff),
      .res_num (res_num),
      .res0    (res0),
      .res1    (res1),
      .status  (status)
   );

   // Results are only pushed when the byte is actually consumed.
   assign pop = rsp_valid && !rsp_stall;

   cwsp_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_num   (fire ? res_num : 2'd0),
      .push0      (res0),
      .push1      (res1),
      .pop        (pop),
      .room       (room),
      .head_valid (rsp_valid),
      .head       (head)
   );

   assign rsp_kind         = head.kind;
   assign rsp_data_byte    = head.data_byte;
   assign rsp_word_count   = head.word_count;
   assign rsp_err_code     = head.err_code;
   assign rsp_error_column = head.error_column;
   assign rsp_last         = head.last;

   // A line-end result is always the final result of its byte.
   a_line_end_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == cwsp_pkg::KIND_LINE_OK ||
                     rsp_kind == cwsp_pkg::KIND_LINE_ERR)) |-> rsp_last)
      else $error("line-end result not marked last");

   // A consumed end-of-line byte leaves a clean line state behind.
   a_line_cleared : assert property (@(posedge clock) disable iff (reset)
      (fire && char_ff == cwsp_pkg::CHAR_EOL) |=>
         (status.mode == cwsp_pkg::MODE_GAP && !status.escape_pending &&
          status.words_zero && status.position_zero))
      else $error("line state not cleared after end of line");

   // A pending escape only exists inside a word or a double-quoted part.
   a_escape_mode : assert property (@(posedge clock) disable iff (reset)
      status.escape_pending |->
         (status.mode == cwsp_pkg::MODE_WORD || status.mode == cwsp_pkg::MODE_DQ))
      else $error("escape pending outside a word");

   // Only byte results carry a data byte.
   a_data_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != cwsp_pkg::KIND_BYTE) |-> (rsp_data_byte == 8'd0))
      else $error("data byte set on a non-byte result");

endmodule
